FILE: rtl/sbd_pkg.sv
// Shared types, constants and sequencer states for the spectral beat detector.
// Used by every module in rtl/ but sbd_addsub; depends on nothing.
package sbd_pkg;

    // Field and datapath widths
    localparam int BIN_W   = 9;
    localparam int MAG_W   = 32;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 8;
    localparam int LVL_W   = 32;
    localparam int THR_W   = 12;
    localparam int LIMIT_W = 9;
    localparam int SUM_W   = 40;
    localparam int DIV_W   = 9;
    localparam int CNT_W   = 6;

    // Algorithm constants
    localparam int SPECTRUM_LEN  = 512;
    localparam int PEAK_END      = SPECTRUM_LEN / 2;
    localparam int PEAK_CMP_W    = 13;
    localparam int DEBOUNCE_MS   = 200;
    localparam int LEAK_SHIFT    = 3;
    localparam int AVG_FRAC_BITS = 8;

    // Register port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_BASS_LOW   = 3'd0;
    localparam logic [2:0] REG_BASS_HIGH  = 3'd1;
    localparam logic [2:0] REG_MID_LOW    = 3'd2;
    localparam logic [2:0] REG_MID_HIGH   = 3'd3;
    localparam logic [2:0] REG_BASS_THR   = 3'd4;
    localparam logic [2:0] REG_MID_THR    = 3'd5;
    localparam logic [2:0] REG_BASS_MIN   = 3'd6;
    localparam logic [2:0] REG_PEAK_LIMIT = 3'd7;

    localparam logic [7:0]         RST_BASS_LOW   = 8'd1;
    localparam logic [7:0]         RST_BASS_HIGH  = 8'd2;
    localparam logic [7:0]         RST_MID_LOW    = 8'd3;
    localparam logic [7:0]         RST_MID_HIGH   = 8'd3;
    localparam logic [THR_W-1:0]   RST_BASS_THR   = 12'd358;
    localparam logic [THR_W-1:0]   RST_MID_THR    = 12'd333;
    localparam logic [31:0]        RST_BASS_MIN   = 32'd100000000;
    localparam logic [LIMIT_W-1:0] RST_PEAK_LIMIT = 9'd4;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_index;
        logic [MAG_W-1:0]  magnitude;
        logic              frame_end;
        logic [TIME_W-1:0] now_ms;
    } sbd_in_t;

    typedef struct packed {
        logic             beat;
        logic [LVL_W-1:0] bass_level;
        logic [LVL_W-1:0] bass_average;
        logic [LVL_W-1:0] mid_level;
        logic [LVL_W-1:0] mid_average;
        logic [IDX_W-1:0] peak_bin;
    } sbd_out_t;

    typedef struct packed {
        logic [7:0]         bass_low_bin;
        logic [7:0]         bass_high_bin;
        logic [7:0]         mid_low_bin;
        logic [7:0]         mid_high_bin;
        logic [THR_W-1:0]   bass_threshold;
        logic [THR_W-1:0]   mid_threshold;
        logic [31:0]        bass_min_average;
        logic [LIMIT_W-1:0] peak_bin_limit;
    } sbd_cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD_B,
        S_DIV_B,
        S_LOAD_M,
        S_DIV_M,
        S_LEAK_BD,
        S_LEAK_BA,
        S_LEAK_MD,
        S_LEAK_MA,
        S_MUL_B,
        S_CMP_B,
        S_MUL_M,
        S_CMP_M,
        S_MIN,
        S_DEB_D,
        S_DEB_C,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/sbd_addsub.sv
// Shared add/subtract unit of the frame-end engine.
// Depends on nothing; width set by the top level.
module sbd_addsub #(
    parameter int W = 52
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic [W:0] full;

    // a - b as a + ~b + 1; carry low on subtract means borrow
    assign full  = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

FILE: rtl/sbd_regs.sv
// Configuration register file behind the APB-style port.
// Depends on sbd_pkg.
module sbd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbd_pkg::PADDR_W-1:0]   paddr,
    input  logic [sbd_pkg::PDATA_W-1:0]   pwdata,
    output logic [sbd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output sbd_pkg::sbd_cfg_t             cfg
);

    sbd_pkg::sbd_cfg_t cfg_reg;
    logic [2:0]        idx;
    logic              wr_en;

    assign idx    = paddr[sbd_pkg::PADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bass_low_bin     <= sbd_pkg::RST_BASS_LOW;
            cfg_reg.bass_high_bin    <= sbd_pkg::RST_BASS_HIGH;
            cfg_reg.mid_low_bin      <= sbd_pkg::RST_MID_LOW;
            cfg_reg.mid_high_bin     <= sbd_pkg::RST_MID_HIGH;
            cfg_reg.bass_threshold   <= sbd_pkg::RST_BASS_THR;
            cfg_reg.mid_threshold    <= sbd_pkg::RST_MID_THR;
            cfg_reg.bass_min_average <= sbd_pkg::RST_BASS_MIN;
            cfg_reg.peak_bin_limit   <= sbd_pkg::RST_PEAK_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (idx)
                sbd_pkg::REG_BASS_LOW:   cfg_reg.bass_low_bin     <= pwdata[7:0];
                sbd_pkg::REG_BASS_HIGH:  cfg_reg.bass_high_bin    <= pwdata[7:0];
                sbd_pkg::REG_MID_LOW:    cfg_reg.mid_low_bin      <= pwdata[7:0];
                sbd_pkg::REG_MID_HIGH:   cfg_reg.mid_high_bin     <= pwdata[7:0];
                sbd_pkg::REG_BASS_THR:
                    cfg_reg.bass_threshold <= pwdata[sbd_pkg::THR_W-1:0];
                sbd_pkg::REG_MID_THR:
                    cfg_reg.mid_threshold <= pwdata[sbd_pkg::THR_W-1:0];
                sbd_pkg::REG_BASS_MIN:   cfg_reg.bass_min_average <= pwdata;
                sbd_pkg::REG_PEAK_LIMIT:
                    cfg_reg.peak_bin_limit <= pwdata[sbd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            sbd_pkg::REG_BASS_LOW:   prdata = {24'd0, cfg_reg.bass_low_bin};
            sbd_pkg::REG_BASS_HIGH:  prdata = {24'd0, cfg_reg.bass_high_bin};
            sbd_pkg::REG_MID_LOW:    prdata = {24'd0, cfg_reg.mid_low_bin};
            sbd_pkg::REG_MID_HIGH:   prdata = {24'd0, cfg_reg.mid_high_bin};
            sbd_pkg::REG_BASS_THR:   prdata = {20'd0, cfg_reg.bass_threshold};
            sbd_pkg::REG_MID_THR:    prdata = {20'd0, cfg_reg.mid_threshold};
            sbd_pkg::REG_BASS_MIN:   prdata = cfg_reg.bass_min_average;
            sbd_pkg::REG_PEAK_LIMIT: prdata = {23'd0, cfg_reg.peak_bin_limit};
            default:                 prdata = '0;
        endcase
    end

endmodule

FILE: rtl/sbd_frame_acc.sv
// Per-frame accumulators: bass and mid band sums and the running peak bin.
// Depends on sbd_pkg.
module sbd_frame_acc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        clear,
    input  sbd_pkg::sbd_in_t            item,
    input  sbd_pkg::sbd_cfg_t           cfg,
    output logic [sbd_pkg::SUM_W-1:0]   bass_sum,
    output logic [sbd_pkg::SUM_W-1:0]   mid_sum,
    output logic [sbd_pkg::IDX_W-1:0]   peak_index
);

    logic [sbd_pkg::SUM_W-1:0] bass_sum_reg, bass_sum_next;
    logic [sbd_pkg::SUM_W-1:0] mid_sum_reg, mid_sum_next;
    logic [sbd_pkg::MAG_W-1:0] peak_level_reg, peak_level_next;
    logic [sbd_pkg::IDX_W-1:0] peak_index_reg, peak_index_next;
    logic [sbd_pkg::SUM_W-1:0] mag_ext;
    logic                      in_bass;
    logic                      in_mid;
    logic                      in_peak;

    assign mag_ext = {{(sbd_pkg::SUM_W - sbd_pkg::MAG_W){1'b0}}, item.magnitude};
    assign in_bass = (item.bin_index >= {1'b0, cfg.bass_low_bin})
                  && (item.bin_index <= {1'b0, cfg.bass_high_bin});
    assign in_mid  = (item.bin_index >= {1'b0, cfg.mid_low_bin})
                  && (item.bin_index <= {1'b0, cfg.mid_high_bin});
    assign in_peak = (item.bin_index != '0)
                  && (sbd_pkg::PEAK_CMP_W'(item.bin_index)
                      < sbd_pkg::PEAK_CMP_W'(sbd_pkg::PEAK_END))
                  && (item.magnitude > peak_level_reg);

    always_comb
    begin
        bass_sum_next   = bass_sum_reg;
        mid_sum_next    = mid_sum_reg;
        peak_level_next = peak_level_reg;
        peak_index_next = peak_index_reg;
        if (clear)
        begin
            bass_sum_next   = '0;
            mid_sum_next    = '0;
            peak_level_next = '0;
            peak_index_next = '0;
        end
        else if (take)
        begin
            if (in_bass)
                bass_sum_next = bass_sum_reg + mag_ext;
            if (in_mid)
                mid_sum_next = mid_sum_reg + mag_ext;
            if (in_peak)
            begin
                peak_level_next = item.magnitude;
                // clamp bins past 255 for large transforms
                peak_index_next = item.bin_index[sbd_pkg::BIN_W-1] ? '1
                                : item.bin_index[sbd_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bass_sum_reg   <= '0;
            mid_sum_reg    <= '0;
            peak_level_reg <= '0;
            peak_index_reg <= '0;
        end
        else
        begin
            bass_sum_reg   <= bass_sum_next;
            mid_sum_reg    <= mid_sum_next;
            peak_level_reg <= peak_level_next;
            peak_index_reg <= peak_index_next;
        end
    end

    assign bass_sum   = bass_sum_reg;
    assign mid_sum    = mid_sum_reg;
    assign peak_index = peak_index_reg;

endmodule

FILE: rtl/spectral_beat_detector_core.sv
// Spectral beat detector top: register port, frame accumulators and frame-end engine.
// A bin item without frame end is taken while the engine is idle, back to back.
// A frame-end item stalls the input through two 40-step divisions, two loads,
// four leak steps, two 12-step shift-add products, four compares, one time difference and
// finish; its result item is registered at the edge that ends the stall, later if blocked.
// Reset clears sums, averages, peak, last beat time and loads the register defaults.
module spectral_beat_detector_core #(
    parameter int AVG_FRAC_BITS = sbd_pkg::AVG_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbd_pkg::PADDR_W-1:0]   paddr,
    input  logic [sbd_pkg::PDATA_W-1:0]   pwdata,
    output logic [sbd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sbd_pkg::sbd_in_t              in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sbd_pkg::sbd_out_t             out_item
);

    localparam int AW = sbd_pkg::LVL_W + AVG_FRAC_BITS;
    localparam int W  = AW + sbd_pkg::THR_W;

    sbd_pkg::sbd_cfg_t          cfg;
    sbd_pkg::state_t            state_reg, state_next;
    logic [sbd_pkg::SUM_W-1:0]  bass_sum;
    logic [sbd_pkg::SUM_W-1:0]  mid_sum;
    logic [sbd_pkg::IDX_W-1:0]  peak_index;
    logic                       in_take;
    logic                       acc_clear;

    logic [sbd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sbd_pkg::DIV_W-1:0]  div_rem_reg, div_rem_next;
    logic [sbd_pkg::DIV_W-1:0]  div_d_reg, div_d_next;
    logic [sbd_pkg::SUM_W-1:0]  div_q_reg, div_q_next;
    logic [sbd_pkg::LVL_W-1:0]  bass_level_reg, bass_level_next;
    logic [sbd_pkg::LVL_W-1:0]  mid_level_reg, mid_level_next;
    logic [AW-1:0]              bass_avg_reg, bass_avg_next;
    logic [AW-1:0]              mid_avg_reg, mid_avg_next;
    logic [W-1:0]               diff_reg, diff_next;
    logic [W-1:0]               prod_reg, prod_next;
    logic [sbd_pkg::THR_W-1:0]  mul_thr_reg, mul_thr_next;
    logic                       bass_ok_reg, bass_ok_next;
    logic                       mid_ok_reg, mid_ok_next;
    logic                       min_ok_reg, min_ok_next;
    logic                       beat_reg, beat_next;
    logic [sbd_pkg::TIME_W-1:0] now_reg, now_next;
    logic [sbd_pkg::TIME_W-1:0] last_beat_reg, last_beat_next;
    logic                       out_valid_reg, out_valid_next;
    sbd_pkg::sbd_out_t          out_item_reg, out_item_next;

    logic [W-1:0]               unit_a;
    logic [W-1:0]               unit_b;
    logic                       unit_sub;
    logic [W-1:0]               unit_sum;
    logic                       unit_carry;
    logic                       unit_borrow;

    logic [sbd_pkg::DIV_W-1:0]  div_trial;
    logic [sbd_pkg::LVL_W-1:0]  div_level;
    logic                       out_free;
    logic                       peak_ok;
    logic [W-1:0]               leak_step;

    sbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbd_frame_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_take),
        .clear      (acc_clear),
        .item       (in_item),
        .cfg        (cfg),
        .bass_sum   (bass_sum),
        .mid_sum    (mid_sum),
        .peak_index (peak_index)
    );

    sbd_addsub #(.W(W)) u_alu (
        .a     (unit_a),
        .b     (unit_b),
        .sub   (unit_sub),
        .sum   (unit_sum),
        .carry (unit_carry)
    );

    assign in_stall    = (state_reg != sbd_pkg::S_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign unit_borrow = unit_sub && !unit_carry;
    assign div_trial   = {div_rem_reg[sbd_pkg::DIV_W-2:0], div_q_reg[sbd_pkg::SUM_W-1]};
    // saturate quotients beyond 32 bits
    assign div_level   = (|div_q_reg[sbd_pkg::SUM_W-1:sbd_pkg::LVL_W]) ? '1
                       : div_q_reg[sbd_pkg::LVL_W-1:0];
    assign peak_ok     = ({1'b0, peak_index} < cfg.peak_bin_limit);
    // floor shift of the signed difference covers both leak directions
    assign leak_step   = W'($signed(diff_reg) >>> sbd_pkg::LEAK_SHIFT);

    // Shared unit operand select
    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        case (state_reg)
            sbd_pkg::S_DIV_B, sbd_pkg::S_DIV_M:
            begin
                unit_a   = {{(W - sbd_pkg::DIV_W){1'b0}}, div_trial};
                unit_b   = {{(W - sbd_pkg::DIV_W){1'b0}}, div_d_reg};
                unit_sub = 1'b1;
            end
            sbd_pkg::S_LEAK_BD:
            begin
                unit_a   = {{(W - sbd_pkg::LVL_W){1'b0}}, bass_level_reg} << AVG_FRAC_BITS;
                unit_b   = {{(W - AW){1'b0}}, bass_avg_reg};
                unit_sub = 1'b1;
            end
            sbd_pkg::S_LEAK_BA:
            begin
                unit_a = {{(W - AW){1'b0}}, bass_avg_reg};
                unit_b = leak_step;
            end
            sbd_pkg::S_LEAK_MD:
            begin
                unit_a   = {{(W - sbd_pkg::LVL_W){1'b0}}, mid_level_reg} << AVG_FRAC_BITS;
                unit_b   = {{(W - AW){1'b0}}, mid_avg_reg};
                unit_sub = 1'b1;
            end
            sbd_pkg::S_LEAK_MA:
            begin
                unit_a = {{(W - AW){1'b0}}, mid_avg_reg};
                unit_b = leak_step;
            end
            sbd_pkg::S_MUL_B:
            begin
                unit_a = prod_reg << 1;
                unit_b = mul_thr_reg[sbd_pkg::THR_W-1] ? {{(W - AW){1'b0}}, bass_avg_reg}
                       : '0;
            end
            sbd_pkg::S_MUL_M:
            begin
                unit_a = prod_reg << 1;
                unit_b = mul_thr_reg[sbd_pkg::THR_W-1] ? {{(W - AW){1'b0}}, mid_avg_reg}
                       : '0;
            end
            sbd_pkg::S_CMP_B:
            begin
                unit_a   = prod_reg;
                unit_b   = {{(W - sbd_pkg::LVL_W){1'b0}}, bass_level_reg}
                           << (AVG_FRAC_BITS + sbd_pkg::THR_W - 4);
                unit_sub = 1'b1;
            end
            sbd_pkg::S_CMP_M:
            begin
                unit_a   = prod_reg;
                unit_b   = {{(W - sbd_pkg::LVL_W){1'b0}}, mid_level_reg}
                           << (AVG_FRAC_BITS + sbd_pkg::THR_W - 4);
                unit_sub = 1'b1;
            end
            sbd_pkg::S_MIN:
            begin
                unit_a   = {{(W - 32){1'b0}}, cfg.bass_min_average} << AVG_FRAC_BITS;
                unit_b   = {{(W - AW){1'b0}}, bass_avg_reg};
                unit_sub = 1'b1;
            end
            sbd_pkg::S_DEB_D:
            begin
                unit_a   = {{(W - sbd_pkg::TIME_W){1'b0}}, now_reg};
                unit_b   = {{(W - sbd_pkg::TIME_W){1'b0}}, last_beat_reg};
                unit_sub = 1'b1;
            end
            sbd_pkg::S_DEB_C:
            begin
                unit_a   = W'(sbd_pkg::DEBOUNCE_MS);
                unit_b   = {{(W - sbd_pkg::TIME_W){1'b0}}, diff_reg[sbd_pkg::TIME_W-1:0]};
                unit_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer: next state and datapath register updates
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        div_rem_next    = div_rem_reg;
        div_d_next      = div_d_reg;
        div_q_next      = div_q_reg;
        bass_level_next = bass_level_reg;
        mid_level_next  = mid_level_reg;
        bass_avg_next   = bass_avg_reg;
        mid_avg_next    = mid_avg_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        mul_thr_next    = mul_thr_reg;
        bass_ok_next    = bass_ok_reg;
        mid_ok_next     = mid_ok_reg;
        min_ok_next     = min_ok_reg;
        beat_next       = beat_reg;
        now_next        = now_reg;
        last_beat_next  = last_beat_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_item_next   = out_item_reg;
        acc_clear       = 1'b0;

        unique case (state_reg)
            sbd_pkg::S_IDLE:
            begin
                if (in_take && in_item.frame_end)
                begin
                    now_next   = in_item.now_ms;
                    state_next = sbd_pkg::S_LOAD_B;
                end
            end
            sbd_pkg::S_LOAD_B:
            begin
                cnt_next     = '0;
                div_rem_next = '0;
                if (cfg.bass_high_bin < cfg.bass_low_bin)
                begin
                    div_q_next = '0;
                    div_d_next = sbd_pkg::DIV_W'(1);
                end
                else
                begin
                    div_q_next = bass_sum;
                    div_d_next = {1'b0, cfg.bass_high_bin} - {1'b0, cfg.bass_low_bin}
                               + sbd_pkg::DIV_W'(1);
                end
                state_next = sbd_pkg::S_DIV_B;
            end
            sbd_pkg::S_DIV_B, sbd_pkg::S_DIV_M:
            begin
                div_rem_next = unit_borrow ? div_trial : unit_sum[sbd_pkg::DIV_W-1:0];
                div_q_next   = {div_q_reg[sbd_pkg::SUM_W-2:0], !unit_borrow};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sbd_pkg::CNT_W'(sbd_pkg::SUM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == sbd_pkg::S_DIV_B) ? sbd_pkg::S_LOAD_M
                               : sbd_pkg::S_LEAK_BD;
                end
            end
            sbd_pkg::S_LOAD_M:
            begin
                bass_level_next = div_level;
                div_rem_next    = '0;
                if (cfg.mid_high_bin < cfg.mid_low_bin)
                begin
                    div_q_next = '0;
                    div_d_next = sbd_pkg::DIV_W'(1);
                end
                else
                begin
                    div_q_next = mid_sum;
                    div_d_next = {1'b0, cfg.mid_high_bin} - {1'b0, cfg.mid_low_bin}
                               + sbd_pkg::DIV_W'(1);
                end
                state_next = sbd_pkg::S_DIV_M;
            end
            sbd_pkg::S_LEAK_BD:
            begin
                mid_level_next = div_level;
                diff_next      = unit_sum;
                state_next     = sbd_pkg::S_LEAK_BA;
            end
            sbd_pkg::S_LEAK_BA:
            begin
                bass_avg_next = unit_sum[AW-1:0];
                state_next    = sbd_pkg::S_LEAK_MD;
            end
            sbd_pkg::S_LEAK_MD:
            begin
                diff_next  = unit_sum;
                state_next = sbd_pkg::S_LEAK_MA;
            end
            sbd_pkg::S_LEAK_MA:
            begin
                mid_avg_next = unit_sum[AW-1:0];
                prod_next    = '0;
                mul_thr_next = cfg.bass_threshold;
                cnt_next     = '0;
                state_next   = sbd_pkg::S_MUL_B;
            end
            sbd_pkg::S_MUL_B, sbd_pkg::S_MUL_M:
            begin
                prod_next    = unit_sum;
                mul_thr_next = mul_thr_reg << 1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sbd_pkg::CNT_W'(sbd_pkg::THR_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == sbd_pkg::S_MUL_B) ? sbd_pkg::S_CMP_B
                               : sbd_pkg::S_CMP_M;
                end
            end
            sbd_pkg::S_CMP_B:
            begin
                bass_ok_next = unit_borrow;
                prod_next    = '0;
                mul_thr_next = cfg.mid_threshold;
                state_next   = sbd_pkg::S_MUL_M;
            end
            sbd_pkg::S_CMP_M:
            begin
                mid_ok_next = unit_borrow;
                state_next  = sbd_pkg::S_MIN;
            end
            sbd_pkg::S_MIN:
            begin
                min_ok_next = unit_borrow;
                state_next  = sbd_pkg::S_DEB_D;
            end
            sbd_pkg::S_DEB_D:
            begin
                diff_next  = unit_sum;
                state_next = sbd_pkg::S_DEB_C;
            end
            sbd_pkg::S_DEB_C:
            begin
                beat_next  = unit_borrow && bass_ok_reg && mid_ok_reg && min_ok_reg
                          && peak_ok;
                state_next = sbd_pkg::S_FINISH;
            end
            sbd_pkg::S_FINISH:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.beat         = beat_reg;
                    out_item_next.bass_level   = bass_level_reg;
                    out_item_next.bass_average =
                        bass_avg_reg[AVG_FRAC_BITS +: sbd_pkg::LVL_W];
                    out_item_next.mid_level    = mid_level_reg;
                    out_item_next.mid_average  =
                        mid_avg_reg[AVG_FRAC_BITS +: sbd_pkg::LVL_W];
                    out_item_next.peak_bin     = peak_index;
                    if (beat_reg)
                        last_beat_next = now_reg;
                    acc_clear  = 1'b1;
                    state_next = sbd_pkg::S_IDLE;
                end
            end
            default: state_next = sbd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbd_pkg::S_IDLE;
            cnt_reg       <= '0;
            bass_avg_reg  <= '0;
            mid_avg_reg   <= '0;
            last_beat_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bass_avg_reg  <= bass_avg_next;
            mid_avg_reg   <= mid_avg_next;
            last_beat_reg <= last_beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg    <= div_rem_next;
        div_d_reg      <= div_d_next;
        div_q_reg      <= div_q_next;
        bass_level_reg <= bass_level_next;
        mid_level_reg  <= mid_level_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        mul_thr_reg    <= mul_thr_next;
        bass_ok_reg    <= bass_ok_next;
        mid_ok_reg     <= mid_ok_next;
        min_ok_reg     <= min_ok_next;
        beat_reg       <= beat_next;
        now_reg        <= now_next;
        out_item_reg   <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A new result only comes out of the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sbd_pkg::S_FINISH))
        else $error("result appeared outside the finish step");

    // A full, stalled output register holds the engine in its finish step
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbd_pkg::S_FINISH && out_valid_reg && out_stall)
        |=> state_reg == sbd_pkg::S_FINISH)
        else $error("engine left finish while output was blocked");

    // Bin items without frame end never start the engine
    a_bin_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbd_pkg::S_IDLE && in_valid && !in_item.frame_end)
        |=> state_reg == sbd_pkg::S_IDLE)
        else $error("engine started on a bin item");

    // Step counter stays inside the division length
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbd_pkg::S_DIV_B || state_reg == sbd_pkg::S_DIV_M)
        |-> cnt_reg < sbd_pkg::CNT_W'(sbd_pkg::SUM_W))
        else $error("division step counter overran");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for spectral_beat_detector_core: APB register setup, random
// spectrum frames with idle and stall phases, and a scoreboard that predicts every frame.
// Depends on rtl/sbd_pkg.sv and rtl/spectral_beat_detector_core.sv.
`timescale 1ns / 100ps

module testbench;

    localparam int THR_FRAC     = 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 130;
    localparam int HOLD_CYCLES  = 800;
    localparam int PHASE_ITEMS  = 60;

    class beat_scoreboard;
        logic [7:0]                  bass_lo, bass_hi, mid_lo, mid_hi;
        logic [sbd_pkg::THR_W-1:0]   bass_thr, mid_thr;
        logic [31:0]                 bass_min;
        logic [sbd_pkg::LIMIT_W-1:0] peak_limit;

        logic [sbd_pkg::SUM_W-1:0]   bass_sum, mid_sum;
        logic [63:0]                 bass_avg, mid_avg;
        logic [sbd_pkg::MAG_W-1:0]   peak_lvl;
        logic [sbd_pkg::IDX_W-1:0]   peak_idx;
        logic [sbd_pkg::TIME_W-1:0]  last_beat_ms;

        sbd_pkg::sbd_out_t frames_due[$];
        int mismatches;

        function new();
            bass_lo = sbd_pkg::RST_BASS_LOW;
            bass_hi = sbd_pkg::RST_BASS_HIGH;
            mid_lo = sbd_pkg::RST_MID_LOW;
            mid_hi = sbd_pkg::RST_MID_HIGH;
            bass_thr = sbd_pkg::RST_BASS_THR;
            mid_thr = sbd_pkg::RST_MID_THR;
            bass_min = sbd_pkg::RST_BASS_MIN;
            peak_limit = sbd_pkg::RST_PEAK_LIMIT;
            bass_sum = '0;
            mid_sum = '0;
            bass_avg = '0;
            mid_avg = '0;
            peak_lvl = '0;
            peak_idx = '0;
            last_beat_ms = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                sbd_pkg::REG_BASS_LOW:   bass_lo = v[7:0];
                sbd_pkg::REG_BASS_HIGH:  bass_hi = v[7:0];
                sbd_pkg::REG_MID_LOW:    mid_lo = v[7:0];
                sbd_pkg::REG_MID_HIGH:   mid_hi = v[7:0];
                sbd_pkg::REG_BASS_THR:   bass_thr = v[sbd_pkg::THR_W-1:0];
                sbd_pkg::REG_MID_THR:    mid_thr = v[sbd_pkg::THR_W-1:0];
                sbd_pkg::REG_BASS_MIN:   bass_min = v;
                sbd_pkg::REG_PEAK_LIMIT: peak_limit = v[sbd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] band_mean(logic [sbd_pkg::SUM_W-1:0] sum, logic [7:0] lo,
                                        logic [7:0] hi);
            logic [sbd_pkg::SUM_W-1:0] q;
            if (hi < lo)
                return '0;
            q = sum / (sbd_pkg::SUM_W'(hi) - sbd_pkg::SUM_W'(lo) + sbd_pkg::SUM_W'(1));
            return (q > sbd_pkg::SUM_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : q[31:0];
        endfunction

        // Move the average toward the new level; round the fall toward the level.
        function logic [63:0] leak(logic [63:0] avg, logic [31:0] level);
            logic [63:0] cur;
            cur = {32'd0, level} << sbd_pkg::AVG_FRAC_BITS;
            if (cur >= avg)
                return avg + ((cur - avg) >> sbd_pkg::LEAK_SHIFT);
            return avg - (((avg - cur) + ((64'd1 << sbd_pkg::LEAK_SHIFT) - 64'd1))
                          >> sbd_pkg::LEAK_SHIFT);
        endfunction

        function bit exceeds(logic [31:0] level, logic [63:0] avg,
                             logic [sbd_pkg::THR_W-1:0] thr);
            return ({32'd0, level} << (sbd_pkg::AVG_FRAC_BITS + THR_FRAC))
                   > avg * {52'd0, thr};
        endfunction

        function void note_bin(sbd_pkg::sbd_in_t it);
            logic [31:0] bl, ml, since;
            bit beat;
            sbd_pkg::sbd_out_t r;
            if (it.bin_index >= sbd_pkg::BIN_W'(bass_lo)
                && it.bin_index <= sbd_pkg::BIN_W'(bass_hi))
                bass_sum = bass_sum + sbd_pkg::SUM_W'(it.magnitude);
            if (it.bin_index >= sbd_pkg::BIN_W'(mid_lo)
                && it.bin_index <= sbd_pkg::BIN_W'(mid_hi))
                mid_sum = mid_sum + sbd_pkg::SUM_W'(it.magnitude);
            if (it.bin_index >= 1 && it.bin_index < sbd_pkg::PEAK_END
                && it.magnitude > peak_lvl)
            begin
                peak_lvl = it.magnitude;
                peak_idx = it.bin_index[sbd_pkg::IDX_W-1:0];
            end
            if (!it.frame_end)
                return;

            bl = band_mean(bass_sum, bass_lo, bass_hi);
            ml = band_mean(mid_sum, mid_lo, mid_hi);
            bass_avg = leak(bass_avg, bl);
            mid_avg = leak(mid_avg, ml);
            since = it.now_ms - last_beat_ms;
            beat = (since > 32'(sbd_pkg::DEBOUNCE_MS)) && exceeds(bl, bass_avg, bass_thr)
                && exceeds(ml, mid_avg, mid_thr) && ({1'b0, peak_idx} < peak_limit)
                && (bass_avg > ({32'd0, bass_min} << sbd_pkg::AVG_FRAC_BITS));
            if (beat)
                last_beat_ms = it.now_ms;

            r.beat = beat;
            r.bass_level = bl;
            r.bass_average = bass_avg[sbd_pkg::AVG_FRAC_BITS +: 32];
            r.mid_level = ml;
            r.mid_average = mid_avg[sbd_pkg::AVG_FRAC_BITS +: 32];
            r.peak_bin = peak_idx;
            frames_due.push_back(r);

            bass_sum = '0;
            mid_sum = '0;
            peak_lvl = '0;
            peak_idx = '0;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: want %0h got %0h", name, want, got);
            end
        endfunction

        function void check_result(sbd_pkg::sbd_out_t got);
            sbd_pkg::sbd_out_t want;
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with none pending: %h", got);
                return;
            end
            want = frames_due.pop_front();
            compare("beat", 32'(want.beat), 32'(got.beat));
            compare("bass_level", want.bass_level, got.bass_level);
            compare("bass_average", want.bass_average, got.bass_average);
            compare("mid_level", want.mid_level, got.mid_level);
            compare("mid_average", want.mid_average, got.mid_average);
            compare("peak_bin", 32'(want.peak_bin), 32'(got.peak_bin));
        endfunction

        function void flush_check();
            if (frames_due.size() != 0)
            begin
                $display("result items never arrived: %0d", frames_due.size());
                mismatches += frames_due.size();
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [sbd_pkg::PADDR_W-1:0]   paddr = '0;
    logic [sbd_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [sbd_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    sbd_pkg::sbd_in_t              in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    sbd_pkg::sbd_out_t             out_item;

    beat_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          items_sent = 0;
    bit          last_fend = 1'b0;
    logic [31:0] ms = '0;
    int          cycles = 0;

    spectral_beat_detector_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_bin(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    // Read one register back and compare it with what was written.
    task automatic apb_check(input logic [2:0] idx, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.compare("register", want, prdata);
    endtask

    task automatic set_config(input logic [7:0] b_lo, input logic [7:0] b_hi,
                              input logic [7:0] m_lo, input logic [7:0] m_hi,
                              input logic [11:0] b_thr, input logic [11:0] m_thr,
                              input logic [31:0] b_min, input logic [8:0] p_lim);
        apb_write(sbd_pkg::REG_BASS_LOW, 32'(b_lo));
        apb_write(sbd_pkg::REG_BASS_HIGH, 32'(b_hi));
        apb_write(sbd_pkg::REG_MID_LOW, 32'(m_lo));
        apb_write(sbd_pkg::REG_MID_HIGH, 32'(m_hi));
        apb_write(sbd_pkg::REG_BASS_THR, 32'(b_thr));
        apb_write(sbd_pkg::REG_MID_THR, 32'(m_thr));
        apb_write(sbd_pkg::REG_BASS_MIN, b_min);
        apb_write(sbd_pkg::REG_PEAK_LIMIT, 32'(p_lim));
        apb_check(sbd_pkg::REG_BASS_LOW, 32'(b_lo));
        apb_check(sbd_pkg::REG_BASS_HIGH, 32'(b_hi));
        apb_check(sbd_pkg::REG_MID_LOW, 32'(m_lo));
        apb_check(sbd_pkg::REG_MID_HIGH, 32'(m_hi));
        apb_check(sbd_pkg::REG_BASS_THR, 32'(b_thr));
        apb_check(sbd_pkg::REG_MID_THR, 32'(m_thr));
        apb_check(sbd_pkg::REG_BASS_MIN, b_min);
        apb_check(sbd_pkg::REG_PEAK_LIMIT, 32'(p_lim));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item and return in the step it is accepted; valid stays high.
    task automatic send(input logic [8:0] bin, input logic [31:0] mag, input bit fend);
        sbd_pkg::sbd_in_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.bin_index = bin;
        it.magnitude = mag;
        it.frame_end = fend;
        it.now_ms = ms;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ms += $urandom_range(0, 3);
        if (fend)
        begin
            ms += $urandom_range(0, 300);
            if ($urandom_range(0, 49) == 0)
                ms = $urandom;
        end
        items_sent++;
        last_fend = fend;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic play_frame();
        int len, first, k;
        bit loud, cut;
        logic [31:0] level, mag;
        logic [8:0] bin;
        if ($urandom_range(0, 99) < 12)
        begin
            // noise: random bins, random frame ends
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
                send(9'($urandom_range(0, 511)), $urandom, $urandom_range(0, 9) == 0);
        end
        else
        begin
            len = $urandom_range(1, 16);
            first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
            loud = ($urandom_range(0, 3) == 0);
            level = loud ? $urandom_range(1000000, 2000000000) : $urandom_range(0, 5000);
            cut = ($urandom_range(0, 19) == 0);
            for (k = 0; k < len; k++)
            begin
                bin = 9'(first + k);
                case ($urandom_range(0, 15))
                    0: mag = 32'd0;
                    1: mag = 32'hFFFFFFFF;
                    2: mag = $urandom;
                    default: mag = (bin < 16) ? level + $urandom_range(0, 1000)
                                              : $urandom_range(0, 5000);
                endcase
                send(bin, mag, (k == len - 1) && !cut);
            end
        end
    endtask

    // Same bin at full scale, enough to wrap the 40-bit band sum.
    task automatic hammer(input logic [8:0] bin);
        int k;
        for (k = 0; k < 260; k++)
            send(bin, 32'hFFFFFFFF, k == 259);
    endtask

    initial
    begin
        int p;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        set_config(8'd1, 8'd1, 8'd2, 8'd3, 12'd256, 12'd256, 32'd0, 9'd256);
        send(9'd1, 32'hFFFFFFFF, 1'b0);
        send(9'd1, 32'hFFFFFFFF, 1'b0);
        send(9'd2, 32'd5, 1'b0);
        send(9'd0, 32'hFFFFFFFF, 1'b0);
        send(9'd300, 32'hFFFFFFFF, 1'b0);
        send(9'd255, 32'hFFFFFFFE, 1'b0);
        send(9'd3, 32'd0, 1'b1);
        send(9'd5, 32'd9, 1'b0);
        send(9'd6, 32'd9, 1'b0);
        send(9'd4, 32'd8, 1'b1);
        send(9'd0, 32'd0, 1'b1);
        send(9'd511, 32'hFFFFFFFF, 1'b0);
        send(9'd256, 32'd7, 1'b0);
        send(9'd2, 32'd1, 1'b1);
        ms = 32'hFFFFFF80;
        send(9'd1, 32'h80000000, 1'b0);
        send(9'd3, 32'h7FFFFFFF, 1'b1);
        ms = 32'hFFFFFFF0;
        send(9'd1, 32'd123456, 1'b1);
        send(9'd2, 32'h55555555, 1'b1);
        send(9'd1, 32'hAAAAAAAA, 1'b1);
        drain();

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(sbd_pkg::RST_BASS_LOW, sbd_pkg::RST_BASS_HIGH,
                              sbd_pkg::RST_MID_LOW, sbd_pkg::RST_MID_HIGH,
                              sbd_pkg::RST_BASS_THR, sbd_pkg::RST_MID_THR,
                              sbd_pkg::RST_BASS_MIN, sbd_pkg::RST_PEAK_LIMIT);
                1: set_config(8'd1, 8'd4, 8'd5, 8'd12, 12'd300, 12'd280, 32'd1000, 9'd16);
                2: set_config(8'd0, 8'd255, 8'd0, 8'd255, 12'd0, 12'd0, 32'd0, 9'd256);
                3: set_config(8'd255, 8'd255, 8'd255, 8'd0, 12'd4095, 12'd4095,
                              32'hFFFFFFFF, 9'd0);
                4: set_config(8'd1, 8'd3, 8'd4, 8'd9, 12'd320, 12'd300, 32'd0, 9'd12);
                5: set_config(8'd10, 8'd2, 8'd2, 8'd7, 12'd256, 12'd256, 32'd0, 9'd8);
                default: set_config(8'($urandom_range(0, 15)), 8'($urandom_range(0, 31)),
                                    8'($urandom_range(0, 15)), 8'($urandom_range(0, 31)),
                                    12'($urandom_range(200, 500)),
                                    12'($urandom_range(200, 500)),
                                    $urandom_range(0, 100000),
                                    9'($urandom_range(0, 256)));
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
            endcase
            // fill the block while the receiver holds off
            if (p == 4)
                hold_req++;
            items_sent = 0;
            if (p == 2)
                hammer(9'd7);
            while (items_sent < PHASE_ITEMS)
                play_frame();
            if (!last_fend)
                send(9'($urandom_range(0, 511)), $urandom, 1'b1);
            drain();
        end

        sb.flush_check();
        if (sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
